// File: sv/fmsd_pkg.sv
`default_nettype none

package fmsd_pkg;

    localparam int HeaderBytesDefault = 12;
    localparam int PosWidth = 4;
    localparam int LenWidth = 32;
    localparam int QueueDepth = 4;
    localparam int QueuePtrWidth = $clog2(QueueDepth);
    localparam int QueueCntWidth = $clog2(QueueDepth + 1);

    localparam logic [PosWidth-1:0] LenFirstPos = 4'd8;
    localparam logic [PosWidth-1:0] LenLastPos = 4'd11;
    localparam logic [7:0] MuBias = 8'h84;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic signed [15:0] mulaw_expand(input logic [7:0] code);
        logic [7:0]  inv;
        logic [7:0]  base;
        logic [14:0] mag;
        begin
            inv = ~code;
            base = {1'b0, inv[3:0], 3'b000} + MuBias;
            mag = 15'({7'd0, base} << inv[6:4]) - 15'(MuBias);
            if (inv[7])
            begin
                mulaw_expand = -$signed({1'b0, mag});
            end
            else
            begin
                mulaw_expand = $signed({1'b0, mag});
            end
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/fmsd_front.sv
`default_nettype none

module fmsd_front #(
    parameter int HEADER_BYTES = fmsd_pkg::HeaderBytesDefault
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   data_valid,
    output logic                        data_stall,
    input  wire logic [7:0]             data_byte,
    input  fmsd_pkg::queue_status_t     q_status,
    output logic                        push,
    output fmsd_pkg::queue_entry_t      push_entry
);
    import fmsd_pkg::*;

    localparam logic [PosWidth-1:0] LastPos = PosWidth'(HEADER_BYTES - 1);

    logic [PosWidth-1:0] header_position_reg;
    logic [PosWidth-1:0] header_position_next;
    logic [LenWidth-1:0] length_gather_reg;
    logic [LenWidth-1:0] length_gather_next;
    logic [LenWidth-1:0] payload_left_reg;
    logic [LenWidth-1:0] payload_left_next;
    logic [LenWidth-1:0] gathered;
    logic                accept;
    logic                in_payload;

    assign data_stall = q_status.full;
    assign accept = data_valid && !data_stall;
    assign in_payload = (payload_left_reg != '0);

    assign push = accept && in_payload;
    assign push_entry.code = data_byte;
    assign push_entry.last = (payload_left_reg == LenWidth'(1));

    always_comb
    begin
        gathered = length_gather_reg;
        if (header_position_reg >= LenFirstPos && header_position_reg <= LenLastPos)
        begin
            case (header_position_reg[1:0])
                2'd0: gathered[7:0] = gathered[7:0] | data_byte;
                2'd1: gathered[15:8] = gathered[15:8] | data_byte;
                2'd2: gathered[23:16] = gathered[23:16] | data_byte;
                2'd3: gathered[31:24] = gathered[31:24] | data_byte;
                default: gathered = length_gather_reg;
            endcase
        end
    end

    always_comb
    begin
        header_position_next = header_position_reg;
        length_gather_next = length_gather_reg;
        payload_left_next = payload_left_reg;
        if (accept)
        begin
            if (in_payload)
            begin
                payload_left_next = payload_left_reg - LenWidth'(1);
            end
            else if (header_position_reg >= LastPos)
            begin
                payload_left_next = gathered;
                length_gather_next = '0;
                header_position_next = '0;
            end
            else
            begin
                length_gather_next = gathered;
                header_position_next = header_position_reg + PosWidth'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_position_reg <= '0;
            length_gather_reg <= '0;
            payload_left_reg <= '0;
        end
        else
        begin
            header_position_reg <= header_position_next;
            length_gather_reg <= length_gather_next;
            payload_left_reg <= payload_left_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/fmsd_queue.sv
`default_nettype none

module fmsd_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  fmsd_pkg::queue_entry_t      push_entry,
    input  wire logic                   pop,
    output fmsd_pkg::queue_entry_t      head_entry,
    output fmsd_pkg::queue_status_t     q_status
);
    import fmsd_pkg::*;

    queue_entry_t             entries_reg [QueueDepth];
    logic [QueuePtrWidth-1:0] wr_ptr_reg;
    logic [QueuePtrWidth-1:0] wr_ptr_next;
    logic [QueuePtrWidth-1:0] rd_ptr_reg;
    logic [QueuePtrWidth-1:0] rd_ptr_next;
    logic [QueueCntWidth-1:0] count_reg;
    logic [QueueCntWidth-1:0] count_next;

    assign q_status.full = (count_reg == QueueCntWidth'(QueueDepth));
    assign q_status.empty = (count_reg == '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QueuePtrWidth'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QueuePtrWidth'(1) : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QueueCntWidth'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QueueCntWidth'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/fmsd_back.sv
`default_nettype none

module fmsd_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  fmsd_pkg::queue_status_t     q_status,
    input  fmsd_pkg::queue_entry_t      head_entry,
    output logic                        pop,
    output logic                        sample_valid,
    input  wire logic                   sample_stall,
    output logic signed [15:0]          sample,
    output logic                        record_end
);
    import fmsd_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic signed [15:0] sample_reg;
    logic               record_end_reg;

    assign pop = !q_status.empty && (!valid_reg || !sample_stall);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (!sample_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sample_reg <= mulaw_expand(head_entry.code);
            record_end_reg <= head_entry.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign sample_valid = valid_reg;
    assign sample = sample_reg;
    assign record_end = record_end_reg;

endmodule

`default_nettype wire

// File: sv/framed_mulaw_stream_decoder.sv
// A payload byte that is accepted is written into the queue, then popped and expanded into the registered
// sample output; a sample stall can hold it in the queue or in the output register before its transaction.
// Throughput is one byte per cycle while data_stall is low; header bytes are absorbed and give no sample.
// A four-entry queue between the parser and the expander absorbs output stalls.
// Asynchronous active-low reset empties the queue and output and expects a header.
`default_nettype none

module framed_mulaw_stream_decoder #(
    parameter int HEADER_BYTES = fmsd_pkg::HeaderBytesDefault
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         data_valid,
    output logic              data_stall,
    input  wire logic [7:0]   data_byte,
    output logic              sample_valid,
    input  wire logic         sample_stall,
    output logic signed [15:0] sample,
    output logic              record_end
);
    import fmsd_pkg::*;

    logic          push;
    logic          pop;
    queue_entry_t  push_entry;
    queue_entry_t  head_entry;
    queue_status_t q_status;

    fmsd_front #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    fmsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    fmsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head_entry   (head_entry),
        .pop          (pop),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .record_end   (record_end)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("Queue written while full.");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("Queue read while empty.");

    a_output_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall && q_status.empty) |=> !sample_valid)
        else $error("Sample transaction repeated with nothing queued.");

endmodule

`default_nettype wire
